@@ src/first_fit_boundary_tag_allocator_defines.svh @@
// assertion macros for the first-fit boundary-tag allocator
// included by the top level; define ASSERT_OFF to drop all checks
`ifndef FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define FFBTA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ffbta assertion failed");
`define FFBTA_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`else
`define FFBTA_ASSERT(lbl, clk, rst_n, prop)
`define FFBTA_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif
`endif

@@ src/ffbta_pkg.sv @@
// shared constants and types for the first-fit boundary-tag allocator
// no dependencies
package ffbta_pkg;

    localparam int HEAP_WORDS_DEF = 4096;

    localparam int ADDR_W   = 12;
    localparam int REQ_W    = 16;
    localparam int BYTES_W  = 16;
    localparam int STATUS_W = 2;

    localparam int TAG_OVERHEAD = 16;
    localparam int SPLIT_LIMIT  = 24;
    localparam int ALIGN_BYTES  = 8;
    localparam int WORD_SHIFT   = 3;

    localparam logic OP_ALLOC = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE   = 2'd0,
        STATUS_NO_FIT = 2'd1,
        STATUS_REJECT = 2'd2
    } t_status;

endpackage

@@ src/ffbta_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ffbta_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/first_fit_boundary_tag_allocator.sv @@
// first-fit boundary-tag heap allocator, one transaction in flight, one result per transaction
// allocate: walks the block headers, writes header and footer, and those of a split remainder
// free: tag reads of the block and its neighbors on one read port, then the merged block is written
// returns to idle between transactions, and waits before that while the previous result is stalled
// reset sweeps the tag memory, with the input stalled, to one free block
// depends on ffbta_pkg, ffbta_ram and first_fit_boundary_tag_allocator_defines.svh
`include "first_fit_boundary_tag_allocator_defines.svh"

module first_fit_boundary_tag_allocator
    import ffbta_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [REQ_W-1:0]    i_request_bytes,
    input  logic [ADDR_W-1:0]   i_free_address,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [ADDR_W-1:0]   o_address,
    output logic [BYTES_W-1:0]  o_block_bytes
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int IW = ((AW > ADDR_W) ? AW : ADDR_W) + 2;
    localparam int HB = HEAP_WORDS * 8;
    localparam int TW = $clog2(HB + 1) + 1;
    localparam int DW = ((TW > REQ_W + 2) ? TW : REQ_W + 2) + 2;

    localparam logic signed [IW-1:0] HW_I = IW'(HEAP_WORDS);
    localparam logic signed [DW-1:0] HB_D = DW'(HB);
    localparam logic signed [TW-1:0] HB_T = TW'(HB);

    typedef enum logic [13:0] {
        ST_CLEAR    = 14'b00000000000001,
        ST_IDLE     = 14'b00000000000010,
        ST_A_RD     = 14'b00000000000100,
        ST_A_CHK    = 14'b00000000001000,
        ST_T_HRD    = 14'b00000000010000,
        ST_T_HCHK   = 14'b00000000100000,
        ST_T_FCHK   = 14'b00000001000000,
        ST_F_LF_RD  = 14'b00000010000000,
        ST_F_LF_CHK = 14'b00000100000000,
        ST_F_RT     = 14'b00001000000000,
        ST_F_CLAMP  = 14'b00010000000000,
        ST_W_HDR    = 14'b00100000000000,
        ST_W_FTR    = 14'b01000000000000,
        ST_FIN      = 14'b10000000000000
    } t_state;

    typedef enum logic [1:0] {
        PH_SELF  = 2'd0,
        PH_LEFT  = 2'd1,
        PH_RIGHT = 2'd2
    } t_phase;

    function automatic logic in_heap(input logic signed [IW-1:0] x);
        return (x >= 0) && (x < HW_I);
    endfunction

    function automatic logic signed [DW-1:0] tag_mag(input logic signed [TW-1:0] t);
        logic signed [DW-1:0] e;
        e = DW'(t);
        return (e < 0) ? -e : e;
    endfunction

    function automatic logic signed [IW-1:0] to_words(input logic signed [DW-1:0] b);
        return IW'(b >>> WORD_SHIFT);
    endfunction

    t_state                r_state, n_state;
    t_phase                r_phase, n_phase;
    logic [AW-1:0]         r_clr, n_clr;
    logic signed [IW-1:0]  r_cur, n_cur;
    logic signed [IW-1:0]  r_h, n_h;
    logic signed [IW-1:0]  r_right, n_right;
    logic signed [IW-1:0]  r_wpos, n_wpos;
    logic signed [TW-1:0]  r_hdr, n_hdr;
    logic signed [DW-1:0]  r_size, n_size;
    logic signed [DW-1:0]  r_avail, n_avail;
    logic signed [DW-1:0]  r_wbytes, n_wbytes;
    logic                  r_wneg, n_wneg;
    logic                  r_split, n_split;
    t_status               r_status, n_status;
    logic [ADDR_W-1:0]     r_res_addr, n_res_addr;
    logic [BYTES_W-1:0]    r_res_bytes, n_res_bytes;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [ADDR_W-1:0]     r_out_addr, n_out_addr;
    logic [BYTES_W-1:0]    r_out_bytes, n_out_bytes;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic signed [TW-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [TW-1:0]         ram_rdata;

    logic signed [TW-1:0]  rd_tag;
    logic signed [DW-1:0]  rd_ext;
    logic signed [DW-1:0]  rd_mag;
    logic signed [IW-1:0]  rd_words;
    logic signed [DW-1:0]  hdr_mag;
    logic signed [IW-1:0]  walk_next;
    logic signed [IW-1:0]  cur_inc;
    logic signed [IW-1:0]  foot_idx;
    logic signed [IW-1:0]  wfoot;
    logic signed [IW-1:0]  wnext;
    logic signed [DW-1:0]  wval;
    logic signed [DW-1:0]  clamp_bytes;
    logic signed [DW-1:0]  merged;
    logic                  sign_ok;
    logic                  chk_done;
    logic                  chk_ok;

    ffbta_ram #(
        .WIDTH (TW),
        .DEPTH (HEAP_WORDS)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_tag      = $signed(ram_rdata);
    assign rd_ext      = DW'(rd_tag);
    assign rd_mag      = tag_mag(rd_tag);
    assign rd_words    = to_words(rd_mag);
    assign hdr_mag     = tag_mag(r_hdr);
    assign walk_next   = r_cur + rd_words;
    assign cur_inc     = r_cur + IW'(1);
    assign foot_idx    = r_h + rd_words - IW'(1);
    assign wnext       = r_wpos + to_words(r_wbytes);
    assign wfoot       = wnext - IW'(1);
    assign wval        = r_wneg ? -r_wbytes : r_wbytes;
    assign clamp_bytes = (r_wbytes > HB_D) ? HB_D : r_wbytes;
    assign merged      = r_wbytes + hdr_mag;
    assign sign_ok     = (r_phase == PH_SELF) ? (rd_tag < 0) : (rd_tag > 0);

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_clr        = r_clr;
        n_cur        = r_cur;
        n_h          = r_h;
        n_right      = r_right;
        n_wpos       = r_wpos;
        n_hdr        = r_hdr;
        n_size       = r_size;
        n_avail      = r_avail;
        n_wbytes     = r_wbytes;
        n_wneg       = r_wneg;
        n_split      = r_split;
        n_status     = r_status;
        n_res_addr   = r_res_addr;
        n_res_bytes  = r_res_bytes;
        n_out_valid  = r_out_valid & i_out_stall;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        n_out_bytes  = r_out_bytes;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;
        chk_done     = 1'b0;
        chk_ok       = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = (r_clr == '0 || r_clr == AW'(HEAP_WORDS - 1)) ? HB_T : '0;
                if (r_clr == AW'(HEAP_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_status    = STATUS_DONE;
                    n_res_addr  = '0;
                    n_res_bytes = '0;
                    if (i_operation == OP_ALLOC) begin
                        n_size  = (DW'(i_request_bytes) + DW'(TAG_OVERHEAD)
                                   + DW'(ALIGN_BYTES - 1)) & ~DW'(ALIGN_BYTES - 1);
                        n_cur   = '0;
                        n_state = ST_A_RD;
                    end else begin
                        n_cur   = IW'(i_free_address) - IW'(1);
                        n_h     = IW'(i_free_address) - IW'(1);
                        n_phase = PH_SELF;
                        n_state = ST_T_HRD;
                    end
                end
            end
            ST_A_RD: begin
                ram_raddr = r_cur[AW-1:0];
                n_state   = ST_A_CHK;
            end
            ST_A_CHK: begin
                if (rd_ext > 0 && rd_ext >= r_size) begin
                    n_avail    = rd_ext;
                    n_wpos     = r_cur;
                    n_wneg     = 1'b1;
                    n_res_addr = cur_inc[ADDR_W-1:0];
                    if (rd_ext - r_size > DW'(SPLIT_LIMIT)) begin
                        n_wbytes    = r_size;
                        n_split     = 1'b1;
                        n_res_bytes = r_size[BYTES_W-1:0];
                    end else begin
                        n_wbytes    = rd_ext;
                        n_split     = 1'b0;
                        n_res_bytes = rd_ext[BYTES_W-1:0];
                    end
                    n_state = ST_W_HDR;
                end else if (rd_words == '0 || walk_next >= HW_I) begin
                    n_status = STATUS_NO_FIT;
                    n_state  = ST_FIN;
                end else begin
                    n_cur   = walk_next;
                    n_state = ST_A_RD;
                end
            end
            ST_T_HRD: begin
                if (in_heap(r_h)) begin
                    ram_raddr = r_h[AW-1:0];
                    n_state   = ST_T_HCHK;
                end else begin
                    chk_done = 1'b1;
                end
            end
            ST_T_HCHK: begin
                n_hdr = rd_tag;
                if (sign_ok && in_heap(foot_idx)) begin
                    ram_raddr = foot_idx[AW-1:0];
                    n_state   = ST_T_FCHK;
                end else begin
                    chk_done = 1'b1;
                end
            end
            ST_T_FCHK: begin
                chk_done = 1'b1;
                chk_ok   = (rd_mag == hdr_mag);
            end
            ST_F_LF_RD: begin
                ram_raddr = r_h[AW-1:0];
                n_state   = ST_F_LF_CHK;
            end
            ST_F_LF_CHK: begin
                n_h     = r_h - rd_words + IW'(1);
                n_phase = PH_LEFT;
                n_state = ST_T_HRD;
            end
            ST_F_RT: begin
                if (r_right < HW_I) begin
                    n_h     = r_right;
                    n_phase = PH_RIGHT;
                    n_state = ST_T_HRD;
                end else begin
                    n_state = ST_F_CLAMP;
                end
            end
            ST_F_CLAMP: begin
                n_wbytes    = clamp_bytes;
                n_res_bytes = clamp_bytes[BYTES_W-1:0];
                n_wneg      = 1'b0;
                n_split     = 1'b0;
                n_state     = ST_W_HDR;
            end
            ST_W_HDR: begin
                if (in_heap(r_wpos)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wpos[AW-1:0];
                    ram_wdata = wval[TW-1:0];
                end
                n_state = ST_W_FTR;
            end
            ST_W_FTR: begin
                if (in_heap(wfoot)) begin
                    ram_we    = 1'b1;
                    ram_waddr = wfoot[AW-1:0];
                    ram_wdata = wval[TW-1:0];
                end
                if (r_split) begin
                    n_wpos   = wnext;
                    n_wbytes = r_avail - r_wbytes;
                    n_wneg   = 1'b0;
                    n_split  = 1'b0;
                    n_state  = ST_W_HDR;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_addr   = r_res_addr;
                    n_out_bytes  = r_res_bytes;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // tag check finished: continue according to which block was checked
        if (chk_done) begin
            case (r_phase)
                PH_SELF: begin
                    if (chk_ok) begin
                        n_wpos   = r_cur;
                        n_wbytes = hdr_mag;
                        n_right  = r_cur + to_words(hdr_mag);
                        n_h      = r_cur - IW'(1);
                        n_state  = (r_cur > IW'(1)) ? ST_F_LF_RD : ST_F_RT;
                    end else begin
                        n_status = STATUS_REJECT;
                        n_state  = ST_FIN;
                    end
                end
                PH_LEFT: begin
                    if (chk_ok) begin
                        n_wpos   = r_h;
                        n_wbytes = merged;
                    end
                    n_state = ST_F_RT;
                end
                PH_RIGHT: begin
                    if (chk_ok) begin
                        n_wbytes = merged;
                    end
                    n_state = ST_F_CLAMP;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase      <= n_phase;
        r_cur        <= n_cur;
        r_h          <= n_h;
        r_right      <= n_right;
        r_wpos       <= n_wpos;
        r_hdr        <= n_hdr;
        r_size       <= n_size;
        r_avail      <= n_avail;
        r_wbytes     <= n_wbytes;
        r_wneg       <= n_wneg;
        r_split      <= n_split;
        r_status     <= n_status;
        r_res_addr   <= n_res_addr;
        r_res_bytes  <= n_res_bytes;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
        r_out_bytes  <= n_out_bytes;
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_address     = r_out_addr;
    assign o_block_bytes = r_out_bytes;

    `FFBTA_ASSERT(a_walk_in_heap, i_clk, i_rst_n,
        r_state == ST_A_RD |-> (r_cur >= 0 && r_cur < HW_I))
    `FFBTA_ASSERT(a_we_states, i_clk, i_rst_n,
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_W_HDR || r_state == ST_W_FTR))
    `FFBTA_ASSERT_MSG(a_tag_range, i_clk, i_rst_n,
        ram_we |-> (ram_wdata <= HB_T && ram_wdata >= -HB_T), "tag beyond heap size")
    `FFBTA_ASSERT(a_result_from_fin, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state) == ST_FIN)
    `FFBTA_ASSERT_MSG(a_fail_zero, i_clk, i_rst_n,
        (r_out_valid && r_out_status != STATUS_DONE) |-> (r_out_addr == '0 && r_out_bytes == '0),
        "failed transaction with nonzero fields")
    `FFBTA_ASSERT(a_bytes_aligned, i_clk, i_rst_n, r_out_valid |-> r_out_bytes[2:0] == 3'd0)

endmodule

@@ sim/first_fit_boundary_tag_allocator_test.sv @@
// self-checking testbench for the first-fit boundary-tag allocator, with its own tag store model
// depends on ffbta_pkg and first_fit_boundary_tag_allocator
module first_fit_boundary_tag_allocator_test;
    import ffbta_pkg::*;

    localparam int   HEAP_BYTES = HEAP_WORDS_DEF * ALIGN_BYTES;
    localparam logic OP_FREE    = ~OP_ALLOC;
    localparam int   MAX_REPORTS = 20;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   address;
        logic [BYTES_W-1:0]  bytes;
    } heap_result_t;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_operation = OP_ALLOC;
    logic [REQ_W-1:0]    i_request_bytes = '0;
    logic [ADDR_W-1:0]   i_free_address = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ADDR_W-1:0]   o_address;
    logic [BYTES_W-1:0]  o_block_bytes;

    int           tag_mem [HEAP_WORDS_DEF];
    heap_result_t expected_heap_results [$];
    heap_result_t oldest_expected;
    int           live_blocks [$];
    int           mismatch_count = 0;
    int           n_alloc = 0, n_granted = 0, n_no_fit = 0;
    int           n_free = 0, n_merged = 0, n_rejected = 0;
    stall_mode_t  stall_mode = STALL_NONE;
    int           stall_span = 0;

    first_fit_boundary_tag_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_request_bytes (i_request_bytes),
        .i_free_address  (i_free_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_address       (o_address),
        .o_block_bytes   (o_block_bytes)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- tag store model ----------------

    function automatic bit word_in_heap(int idx);
        return idx >= 0 && idx < HEAP_WORDS_DEF;
    endfunction

    function automatic int tag_rd(int idx);
        return word_in_heap(idx) ? tag_mem[idx] : 0;
    endfunction

    function automatic void tag_wr(int idx, int value);
        if (!word_in_heap(idx)) return;
        if (value > HEAP_BYTES) value = HEAP_BYTES;
        if (value < -HEAP_BYTES) value = -HEAP_BYTES;
        tag_mem[idx] = value;
    endfunction

    function automatic int magnitude(int value);
        return value < 0 ? -value : value;
    endfunction

    function automatic void write_tags(int pos, int nbytes, bit allocated);
        int value;
        value = allocated ? -nbytes : nbytes;
        tag_wr(pos, value);
        tag_wr(pos + nbytes / ALIGN_BYTES - 1, value);
    endfunction

    function automatic bit tags_agree(int head);
        int m;
        int foot;
        if (!word_in_heap(head)) return 1'b0;
        m = magnitude(tag_rd(head));
        foot = head + m / ALIGN_BYTES - 1;
        if (!word_in_heap(foot)) return 1'b0;
        return m == magnitude(tag_rd(foot));
    endfunction

    function automatic void reset_heap_model();
        foreach (tag_mem[i]) tag_mem[i] = 0;
        write_tags(0, HEAP_BYTES, 1'b0);
    endfunction

    function automatic heap_result_t predict_heap_op(logic op, logic [REQ_W-1:0] req,
                                                      logic [ADDR_W-1:0] faddr);
        heap_result_t res;
        int need, cur, hit, avail, t, stride;
        int blockh, blk, fstart, fsz, lfoot, left, right;
        res.status  = STATUS_DONE;
        res.address = '0;
        res.bytes   = '0;
        if (op == OP_ALLOC) begin
            need = int'(req) + TAG_OVERHEAD;
            need = (need + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
            cur = 0;
            hit = -1;
            avail = 0;
            // first-fit walk, stops on a zero-size tag
            while (cur < HEAP_WORDS_DEF) begin
                t = tag_rd(cur);
                stride = magnitude(t) / ALIGN_BYTES;
                if (t > 0 && t >= need) begin
                    hit = cur;
                    avail = t;
                    break;
                end
                if (stride == 0) break;
                cur += stride;
            end
            if (hit < 0) begin
                res.status = STATUS_NO_FIT;
            end else begin
                if (avail - need > SPLIT_LIMIT) begin
                    write_tags(hit, need, 1'b1);
                    write_tags(hit + need / ALIGN_BYTES, avail - need, 1'b0);
                    res.bytes = BYTES_W'(need);
                end else begin
                    write_tags(hit, avail, 1'b1);
                    res.bytes = BYTES_W'(avail);
                end
                res.address = ADDR_W'(hit + 1);
            end
        end else begin
            blockh = int'(faddr) - 1;
            blk = -tag_rd(blockh);
            if (!word_in_heap(blockh) || blk <= 0 || !tags_agree(blockh)) begin
                res.status = STATUS_REJECT;
            end else begin
                fstart = blockh;
                fsz = blk;
                lfoot = blockh - 1;
                right = blockh + blk / ALIGN_BYTES;
                if (lfoot > 0) begin
                    left = lfoot - magnitude(tag_rd(lfoot)) / ALIGN_BYTES + 1;
                    if (tags_agree(left) && tag_rd(left) > 0) begin
                        fstart = left;
                        fsz += tag_rd(left);
                    end
                end
                if (right < HEAP_WORDS_DEF) begin
                    if (tags_agree(right) && tag_rd(right) > 0) fsz += tag_rd(right);
                end
                if (fsz > HEAP_BYTES) fsz = HEAP_BYTES;
                write_tags(fstart, fsz, 1'b0);
                res.bytes = BYTES_W'(fsz);
            end
        end
        return res;
    endfunction

    // ---------------- stimulus ----------------

    // arg is the request size for an allocate, the payload word for a free
    task automatic issue_heap_op(input logic op, input int arg, output heap_result_t res);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        if (op == OP_ALLOC) begin
            i_request_bytes <= REQ_W'(arg);
            i_free_address  <= ADDR_W'($urandom);
        end else begin
            i_request_bytes <= REQ_W'($urandom);
            i_free_address  <= ADDR_W'(arg);
        end
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        res = predict_heap_op(i_operation, i_request_bytes, i_free_address);
        expected_heap_results.push_back(res);
        if (op == OP_ALLOC) begin
            n_alloc++;
            if (res.status == STATUS_DONE) n_granted++;
            else n_no_fit++;
        end else begin
            n_free++;
            if (res.status == STATUS_DONE) n_merged++;
            else n_rejected++;
        end
    endtask

    function automatic void drop_live(int addr);
        for (int i = live_blocks.size() - 1; i >= 0; i--)
            if (live_blocks[i] == addr) live_blocks.delete(i);
    endfunction

    // a stale header left by merges is freed a second time and stamps a tag
    // into the payload of a live block, so the next walk meets a zero tag
    task automatic test_stale_tag_walk();
        heap_result_t res;
        issue_heap_op(OP_ALLOC, 48, res);
        issue_heap_op(OP_ALLOC, 48, res);
        issue_heap_op(OP_ALLOC, 48, res);
        issue_heap_op(OP_ALLOC, 112, res);
        issue_heap_op(OP_FREE, 12, res);
        issue_heap_op(OP_FREE, 1, res);
        issue_heap_op(OP_FREE, 17, res);
        issue_heap_op(OP_FREE, 9, res);
        issue_heap_op(OP_FREE, 9, res);
        issue_heap_op(OP_ALLOC, 600, res);
        // merge past the heap size, saturates
        issue_heap_op(OP_FREE, 25, res);
    endtask

    task automatic test_size_extremes();
        heap_result_t res;
        issue_heap_op(OP_ALLOC, 0, res);
        issue_heap_op(OP_FREE, 1, res);
        issue_heap_op(OP_ALLOC, 32768, res);
        // remainder of exactly 24 bytes stays unsplit
        issue_heap_op(OP_ALLOC, 32728, res);
        issue_heap_op(OP_ALLOC, 0, res);
        issue_heap_op(OP_FREE, 1, res);
        // remainder of 32 bytes is split off
        issue_heap_op(OP_ALLOC, 32720, res);
        issue_heap_op(OP_FREE, 1, res);
        issue_heap_op(OP_ALLOC, 32752, res);
        issue_heap_op(OP_FREE, 1, res);
    endtask

    task automatic test_rejected_frees();
        heap_result_t res;
        issue_heap_op(OP_FREE, 0, res);
        issue_heap_op(OP_FREE, 4095, res);
        issue_heap_op(OP_FREE, 1, res);
    endtask

    task automatic test_random_traffic(input int n_items);
        heap_result_t res;
        int sent, burst, pick, sel, idx, target, last_freed;
        sent = 0;
        last_freed = 1;
        while (sent < n_items) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    sel = $urandom_range(0, 3);
                    case (sel)
                        0: target = $urandom_range(0, 4095);
                        1: target = 0;
                        2: target = last_freed;
                        default: begin
                            if (live_blocks.size() != 0)
                                target = live_blocks[$urandom_range(0, live_blocks.size() - 1)]
                                         + $urandom_range(1, 3);
                            else
                                target = $urandom_range(1, 4095);
                        end
                    endcase
                    issue_heap_op(OP_FREE, target, res);
                    if (res.status == STATUS_DONE) drop_live(target);
                end else if (live_blocks.size() < 8 || (pick < 55 && live_blocks.size() < 48)) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 6) target = $urandom_range(0, 128);
                    else if (sel < 8) target = $urandom_range(129, 1024);
                    else if (sel < 9) target = $urandom_range(1025, 8192);
                    else target = $urandom_range(8193, 32768);
                    issue_heap_op(OP_ALLOC, target, res);
                    if (res.status == STATUS_DONE) begin
                        drop_live(res.address);
                        live_blocks.push_back(res.address);
                    end
                end else begin
                    idx = $urandom_range(0, live_blocks.size() - 1);
                    target = live_blocks[idx];
                    issue_heap_op(OP_FREE, target, res);
                    live_blocks.delete(idx);
                    last_freed = target;
                end
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    // ---------------- result side ----------------

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= stall_mode_t'($urandom_range(0, 2));
            stall_span <= $urandom_range(16, 200);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_RANDOM: i_out_stall <= ($urandom_range(0, 2) == 0);
            default:      i_out_stall <= ((stall_span % 6) < 2);
        endcase
    end

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_heap_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected transaction, expected none, actual status %0d",
                             $time, o_status);
            end else begin
                oldest_expected = expected_heap_results.pop_front();
                if (o_status !== oldest_expected.status)
                    note_mismatch("status", oldest_expected.status, o_status);
                if (o_address !== oldest_expected.address)
                    note_mismatch("address", oldest_expected.address, o_address);
                if (o_block_bytes !== oldest_expected.bytes)
                    note_mismatch("block_bytes", oldest_expected.bytes, o_block_bytes);
            end
        end
    end

    // ---------------- run control ----------------

    initial begin
        reset_heap_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_stale_tag_walk();
        test_size_extremes();
        test_rejected_frees();
        test_random_traffic(2000);
        i_in_valid <= 1'b0;
        while (expected_heap_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        $display("covered %0d allocates (%0d granted, %0d no fit) and %0d frees",
                 n_alloc, n_granted, n_no_fit, n_free);
        $display("frees: %0d merged, %0d rejected, under random sender gaps and result stalls",
                 n_merged, n_rejected);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #500_000_000;
        $display("timeout with %0d transactions outstanding", expected_heap_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
